// File: hdl/nsp_pkg.sv
// Package for the nearest segment pick block: payload structs, constants and
// the front-to-back queue entry type. No dependencies.
`default_nettype none
package nsp_pkg;

	localparam int MaxTargetsDefault = 1024;
	localparam int TFracBitsDefault = 16;

	// Configuration register indexes.
	localparam logic [1:0] REG_PICK_X = 2'd0;
	localparam logic [1:0] REG_PICK_Y = 2'd1;
	localparam logic [1:0] REG_PICK_TOL = 2'd2;

	localparam logic [11:0] TolResetValue = 12'd128;

	typedef struct packed {
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic               starts_line;
		logic               owner_kind;
		logic [9:0]         owner_index;
		logic               is_last;
	} vertex_t;

	typedef struct packed {
		logic        hit;
		logic        hit_kind;
		logic [9:0]  hit_index;
		logic [23:0] hit_distance_sq;
	} pick_result_t;

	// One classified request from the front part to the back part.
	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] bx;
		logic signed [15:0] by;
		logic               test_seg;
		logic               kind;
		logic [9:0]         index;
		logic               last;
	} seg_req_t;

endpackage
`default_nettype wire

// File: hdl/nsp_front.sv
// Front part of the nearest segment pick: accepts vertices, pairs each with
// the previous vertex of its polyline and saturates the owner index.
// Depends on nsp_pkg.
`default_nettype none
module nsp_front #(
	parameter int MAX_TARGETS = nsp_pkg::MaxTargetsDefault
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	input  nsp_pkg::vertex_t   in_data,
	output logic               in_stall,
	output logic               req_valid,
	output nsp_pkg::seg_req_t  req_data,
	input  wire                req_stall
);
	import nsp_pkg::*;

	localparam logic [10:0] IdxMax = (MAX_TARGETS >= 1024) ? 11'd1023
		: 11'(MAX_TARGETS - 1);

	logic signed [15:0] prev_x_q;
	logic signed [15:0] prev_y_q;
	logic               have_prev_q;
	logic               take;
	logic [9:0]         idx_sat;

	assign in_stall = req_stall;
	assign take     = in_valid && !req_stall;
	assign idx_sat  = ({1'b0, in_data.owner_index} > IdxMax) ? IdxMax[9:0]
		: in_data.owner_index;

	// Classification is pure logic; the queue registers it.
	always_comb begin
		req_valid         = in_valid;
		req_data.ax       = prev_x_q;
		req_data.ay       = prev_y_q;
		req_data.bx       = in_data.vertex_x;
		req_data.by       = in_data.vertex_y;
		req_data.test_seg = have_prev_q && !in_data.starts_line;
		req_data.kind     = in_data.owner_kind;
		req_data.index    = idx_sat;
		req_data.last     = in_data.is_last;
	end

	// Previous vertex tracking; the last vertex clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			have_prev_q <= 1'b0;
		end else if (take) begin
			prev_x_q    <= in_data.is_last ? 16'sd0 : in_data.vertex_x;
			prev_y_q    <= in_data.is_last ? 16'sd0 : in_data.vertex_y;
			have_prev_q <= !in_data.is_last;
		end
	end

endmodule
`default_nettype wire

// File: hdl/nsp_queue.sv
// Two-entry queue between front and back parts of the nearest segment pick.
// Depends on nsp_pkg.
`default_nettype none
module nsp_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                wr_valid,
	input  nsp_pkg::seg_req_t  wr_data,
	output logic               wr_stall,
	output logic               rd_valid,
	output nsp_pkg::seg_req_t  rd_data,
	input  wire                rd_take
);
	import nsp_pkg::*;

	seg_req_t  mem_q [2];
	logic      wr_ptr_q;
	logic      rd_ptr_q;
	logic [1:0] count_q;
	logic      push;
	logic      pop;

	assign wr_stall = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_take && rd_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

// File: hdl/nsp_back.sv
// Back part of the nearest segment pick: segment distance with a serial
// divider, nearest tracking and result register. Depends on nsp_pkg.
`default_nettype none
module nsp_back #(
	parameter int T_FRAC_BITS = nsp_pkg::TFracBitsDefault
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   req_valid,
	input  nsp_pkg::seg_req_t     req_data,
	output logic                  req_take,
	input  wire signed [15:0]     pick_x,
	input  wire signed [15:0]     pick_y,
	input  wire [11:0]            pick_tolerance,
	input  wire                   tol_write,
	input  wire [11:0]            tol_wdata,
	output logic                  busy,
	output logic                  out_valid,
	output nsp_pkg::pick_result_t out_data,
	input  wire                   out_stall
);
	import nsp_pkg::*;

	localparam int TW = T_FRAC_BITS + 1;
	localparam int CW = $clog2(T_FRAC_BITS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PROD  = 3'd1;
	localparam logic [2:0] ST_SUM   = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_OFS   = 3'd4;
	localparam logic [2:0] ST_SQ    = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]          state_q;
	seg_req_t            req_q;
	logic signed [16:0]  ex_q, ey_q, rx_q, ry_q;
	logic signed [34:0]  pxx_q, pyy_q, pxr_q, pyr_q;
	logic [34:0]         den_q;
	logic signed [35:0]  num_q;
	logic [35:0]         rem_q;
	logic [TW-1:0]       t_q;
	logic [CW-1:0]       cnt_q;
	logic signed [17+TW:0] ox_q, oy_q;
	logic [34:0]         dx_q, dy_q;
	logic [24:0]         nearest_q;
	logic                found_q;
	logic                kind_q;
	logic [9:0]          index_q;
	logic [23:0]         tol_sq;
	logic [23:0]         tol_wr_sq;
	logic [36:0]         rem_sh;
	logic [35:0]         seg_dist;
	logic signed [17:0]  dxn, dyn;

	assign tol_sq    = 24'(pick_tolerance * pick_tolerance);
	assign tol_wr_sq = 24'(tol_wdata * tol_wdata);
	assign req_take  = (state_q == ST_IDLE) && req_valid;
	assign busy      = (state_q != ST_IDLE) || req_valid || out_valid;
	assign rem_sh    = {rem_q, 1'b0};
	assign dxn       = 18'(rx_q - (ox_q >>> T_FRAC_BITS));
	assign dyn       = 18'(ry_q - (oy_q >>> T_FRAC_BITS));
	assign seg_dist  = {1'b0, dx_q} + {1'b0, dy_q};

	// Sequencer: products, sums, restoring division, offsets, distance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (req_valid) begin
					state_q <= req_data.test_seg ? ST_PROD : ST_DONE;
				end
				ST_PROD: state_q <= ST_SUM;
				ST_SUM: begin
					state_q <= ST_DIV;
				end
				ST_DIV: if (cnt_q == '0) begin
					state_q <= ST_OFS;
				end
				ST_OFS: state_q <= ST_SQ;
				ST_SQ:  state_q <= ST_DONE;
				ST_DONE: if (!out_valid || !out_stall || !req_q.last) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q <= req_data;
				ex_q  <= 17'(req_data.bx) - 17'(req_data.ax);
				ey_q  <= 17'(req_data.by) - 17'(req_data.ay);
				rx_q  <= 17'(pick_x) - 17'(req_data.ax);
				ry_q  <= 17'(pick_y) - 17'(req_data.ay);
			end
			ST_PROD: begin
				pxx_q <= 35'(ex_q * ex_q);
				pyy_q <= 35'(ey_q * ey_q);
				pxr_q <= 35'(rx_q * ex_q);
				pyr_q <= 35'(ry_q * ey_q);
			end
			ST_SUM: begin
				den_q <= 35'(pxx_q + pyy_q);
				num_q <= 36'(pxr_q) + 36'(pyr_q);
				rem_q <= '0;
				t_q   <= '0;
				cnt_q <= CW'(T_FRAC_BITS);
			end
			ST_DIV: begin
				// One quotient bit a cycle; the first step settles clamps or loads the remainder.
				if (den_q == '0 || num_q <= 0) begin
					t_q   <= '0;
					cnt_q <= '0;
				end else if (num_q >= $signed({1'b0, den_q})) begin
					t_q   <= TW'(1) << T_FRAC_BITS;
					cnt_q <= '0;
				end else begin
					if (cnt_q == CW'(T_FRAC_BITS)) begin
						rem_q <= 36'(num_q);
						cnt_q <= cnt_q - 1'b1;
					end else begin
						if (rem_sh >= {2'b0, den_q}) begin
							rem_q <= 36'(rem_sh - {2'b0, den_q});
							t_q   <= {t_q[TW-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh[35:0];
							t_q   <= {t_q[TW-2:0], 1'b0};
						end
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end
			ST_OFS: begin
				ox_q <= (18+TW)'(ex_q * $signed({1'b0, t_q}));
				oy_q <= (18+TW)'(ey_q * $signed({1'b0, t_q}));
			end
			ST_SQ: begin
				dx_q <= 35'(dxn * dxn);
				dy_q <= 35'(dyn * dyn);
			end
			default: ;
		endcase
	end

	// Nearest tracking, result register and clear after the last vertex.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nearest_q <= 25'd16384;
			found_q   <= 1'b0;
			kind_q    <= 1'b0;
			index_q   <= '0;
			out_valid <= 1'b0;
			out_data  <= '0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (tol_write && !found_q) begin
				nearest_q <= {1'b0, tol_wr_sq};
			end
			if (state_q == ST_DONE && (!out_valid || !out_stall || !req_q.last)) begin
				logic        f;
				logic        k;
				logic [9:0]  ix;
				logic [24:0] n;
				f  = found_q;
				k  = kind_q;
				ix = index_q;
				n  = nearest_q;
				if (req_q.test_seg && seg_dist <= {11'd0, nearest_q}) begin
					f  = 1'b1;
					k  = req_q.kind;
					ix = req_q.index;
					n  = seg_dist[24:0];
				end
				if (req_q.last) begin
					out_valid <= 1'b1;
					out_data.hit             <= f;
					out_data.hit_kind        <= f ? k : 1'b0;
					out_data.hit_index       <= f ? ix : 10'd0;
					out_data.hit_distance_sq <= n[23:0];
					nearest_q <= {1'b0, tol_sq};
					found_q   <= 1'b0;
					kind_q    <= 1'b0;
					index_q   <= '0;
				end else begin
					nearest_q <= n;
					found_q   <= f;
					kind_q    <= k;
					index_q   <= ix;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/nearest_segment_pick.sv
// Top level of the nearest segment pick: configuration registers, front
// part, queue and back part. Depends on nsp_pkg and the nsp_* modules.
//
//  Channel  Handshake            Payload
//  vertex   in_valid/in_stall    nsp_pkg::vertex_t
//  result   out_valid/out_stall  nsp_pkg::pick_result_t
//  config   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A vertex that tests a segment runs through the product, sum, division,
// offset and distance states of the back part, the division of t giving
// one bit per cycle; when t clamps or the segment is degenerate the
// division ends at once. A vertex that tests no segment goes straight to
// the result state. The two-entry queue lets the front part accept while
// the back part works. Reset is asynchronous; out_stall holds the result
// register and, on a last vertex, the back part.
`default_nettype none
module nearest_segment_pick #(
	parameter int MAX_TARGETS = nsp_pkg::MaxTargetsDefault,
	parameter int T_FRAC_BITS = nsp_pkg::TFracBitsDefault
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  nsp_pkg::vertex_t      in_data,
	output logic                  in_stall,
	output logic                  out_valid,
	output nsp_pkg::pick_result_t out_data,
	input  wire                   out_stall,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire [1:0]             cfg_index,
	input  wire [15:0]            cfg_data
);
	import nsp_pkg::*;

	logic signed [15:0] pick_x_q;
	logic signed [15:0] pick_y_q;
	logic [11:0]        pick_tol_q;
	logic               cfg_wr;
	logic               fr_valid, fr_stall;
	seg_req_t           fr_data;
	logic               bk_valid, bk_take, busy;
	seg_req_t           bk_data;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_x_q   <= '0;
			pick_y_q   <= '0;
			pick_tol_q <= TolResetValue;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_PICK_X:   pick_x_q   <= cfg_data;
				REG_PICK_Y:   pick_y_q   <= cfg_data;
				REG_PICK_TOL: pick_tol_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	nsp_front #(.MAX_TARGETS(MAX_TARGETS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
		.req_valid(fr_valid), .req_data(fr_data), .req_stall(fr_stall)
	);

	nsp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fr_valid), .wr_data(fr_data), .wr_stall(fr_stall),
		.rd_valid(bk_valid), .rd_data(bk_data), .rd_take(bk_take)
	);

	nsp_back #(.T_FRAC_BITS(T_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.req_valid(bk_valid), .req_data(bk_data), .req_take(bk_take),
		.pick_x(pick_x_q), .pick_y(pick_y_q), .pick_tolerance(pick_tol_q),
		.tol_write(cfg_wr && cfg_index == REG_PICK_TOL),
		.tol_wdata(cfg_data[11:0]),
		.busy(busy),
		.out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
	);

`ifndef SYNTHESIS
	// No hit reports zero kind and index.
	a_nohit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.hit_kind == 1'b0
			&& out_data.hit_index == 10'd0)
		else $error("no-hit result carries a target");
	// When the queue is full, a take by the back part always finds a valid entry.
	a_queue_full: assert property (@(posedge clk) disable iff (!arst_n)
		fr_stall |-> !bk_take || bk_valid)
		else $error("queue full without a pending entry");
	// A result held under stall stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	// Busy covers any pending result.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy)
		else $error("result pending while idle");
`endif

endmodule
`default_nettype wire

// File: verif/nearest_segment_pick_checker.sv
// Checker for the nearest segment pick: watches the vertex, result and config
// channels, predicts every pick result and compares it. Depends on nsp_pkg.
`timescale 1ns / 1ps
module nearest_segment_pick_checker (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  wire                   in_stall,
	input  nsp_pkg::vertex_t      in_data,
	input  wire                   out_valid,
	input  wire                   out_stall,
	input  nsp_pkg::pick_result_t out_data,
	input  wire                   cfg_valid,
	input  wire                   cfg_ready,
	input  wire [1:0]             cfg_index,
	input  wire [15:0]            cfg_data,
	output int                    fail_count,
	output int                    pending_count
);
	import nsp_pkg::*;

	localparam int TFrac = 16;

	// Shadow registers and running pick state.
	logic signed [15:0] px, py;
	logic [11:0]        tol;
	logic signed [15:0] last_x, last_y;
	bit                 last_valid;
	longint unsigned    best_sq;
	bit                 have_hit;
	logic               win_kind;
	logic [9:0]         win_index;

	pick_result_t picks_due[$];

	// Squared distance from the pick point to segment a-b, unsigned integer in squared coordinate units.
	function automatic longint unsigned seg_sq(longint ax, longint ay, longint bx,
			longint by);
		longint ex, ey, rx, ry, den, num, t, dx, dy;
		ex = bx - ax;
		ey = by - ay;
		rx = longint'(px) - ax;
		ry = longint'(py) - ay;
		den = ex * ex + ey * ey;
		num = rx * ex + ry * ey;
		if (den <= 0 || num <= 0)
			t = 0;
		else if (num >= den)
			t = longint'(1) << TFrac;
		else
			t = (num << TFrac) / den;
		// Arithmetic shift floors toward minus infinity.
		dx = rx - ((ex * t) >>> TFrac);
		dy = ry - ((ey * t) >>> TFrac);
		return longint'(dx * dx + dy * dy);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	assign pending_count = picks_due.size();

	// Predict on each accepted request and compare each accepted result.
	always @(posedge clk or negedge arst_n) begin
		pick_result_t exp_r;
		longint unsigned d;
		if (!arst_n) begin
			px = 0;
			py = 0;
			tol = TolResetValue;
			last_x = 0;
			last_y = 0;
			last_valid = 0;
			best_sq = longint'(TolResetValue) * TolResetValue;
			have_hit = 0;
			win_kind = 0;
			win_index = 0;
			picks_due.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PICK_X: px = cfg_data;
					REG_PICK_Y: py = cfg_data;
					REG_PICK_TOL: begin
						tol = cfg_data[11:0];
						if (!have_hit)
							best_sq = longint'(tol) * tol;
					end
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (last_valid && !in_data.starts_line) begin
					d = seg_sq(last_x, last_y, in_data.vertex_x, in_data.vertex_y);
					if (d <= best_sq) begin
						best_sq = d;
						have_hit = 1;
						win_kind = in_data.owner_kind;
						win_index = in_data.owner_index;
					end
				end
				last_x = in_data.vertex_x;
				last_y = in_data.vertex_y;
				last_valid = 1;
				if (in_data.is_last) begin
					exp_r.hit = have_hit;
					exp_r.hit_kind = have_hit ? win_kind : 1'b0;
					exp_r.hit_index = have_hit ? win_index : 10'd0;
					exp_r.hit_distance_sq = best_sq[23:0];
					picks_due = {picks_due, exp_r};
					last_x = 0;
					last_y = 0;
					last_valid = 0;
					best_sq = longint'(tol) * tol;
					have_hit = 0;
					win_kind = 0;
					win_index = 0;
				end
			end
			if (out_valid && !out_stall) begin
				if (picks_due.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					exp_r = picks_due.pop_front();
					if (out_data.hit !== exp_r.hit)
						report_mismatch("hit", out_data.hit, exp_r.hit);
					if (out_data.hit_kind !== exp_r.hit_kind)
						report_mismatch("hit_kind", out_data.hit_kind, exp_r.hit_kind);
					if (out_data.hit_index !== exp_r.hit_index)
						report_mismatch("hit_index", out_data.hit_index, exp_r.hit_index);
					if (out_data.hit_distance_sq !== exp_r.hit_distance_sq)
						report_mismatch("hit_distance_sq", out_data.hit_distance_sq,
							exp_r.hit_distance_sq);
				end
			end
		end
	end
endmodule

// File: verif/nearest_segment_pick_tb.sv
// Top of the nearest segment pick testbench: clock, reset, vertex and config
// stimulus, result-side stalls and the verdict. Depends on nsp_pkg, the block
// and nearest_segment_pick_checker.
`timescale 1ns / 1ps
module nearest_segment_pick_tb;
	import nsp_pkg::*;

	localparam int CycleLimit = 1000000;
	localparam int SettleCycles = 80;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	vertex_t          in_data;
	logic             in_stall;
	logic             out_valid;
	pick_result_t     out_data;
	logic             out_stall;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [1:0]       cfg_index;
	logic [15:0]      cfg_data;
	int               fail_count;
	int               pending_count;

	logic             in_fire_q, cfg_fire_q;
	bit               quiet;
	bit               hold_go;
	bit               hold_done;
	int               long_hold;
	int               cycles;
	int               sent;
	logic signed [15:0] cur_px, cur_py;
	logic [11:0]      cur_tol;

	nearest_segment_pick u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
		.out_valid(out_valid), .out_data(out_data), .out_stall(out_stall),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	nearest_segment_pick_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Handshakes seen at the last rising edge, read back at the falling edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_fire_q <= 0;
			cfg_fire_q <= 0;
		end else begin
			in_fire_q <= in_valid && !in_stall;
			cfg_fire_q <= cfg_valid && cfg_ready;
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("nearest_segment_pick_tb NOT OK");
			$finish;
		end
	end

	// Result side: random stalls, a quiet stretch, and one long hold-off.
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				long_hold = 400;
				hold_done = 1;
			end
			if (long_hold > 0) begin
				out_stall <= 1;
				long_hold--;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 29);
			end
		end
	end

	task automatic put(logic signed [15:0] x, logic signed [15:0] y, bit s, bit k,
			logic [9:0] i, bit l);
		vertex_t v;
		v.vertex_x = x;
		v.vertex_y = y;
		v.starts_line = s;
		v.owner_kind = k;
		v.owner_index = i;
		v.is_last = l;
		while (!quiet && $urandom_range(99) < 29) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_data <= v;
		do @(negedge clk); while (!in_fire_q);
		sent++;
	endtask

	// Let every pending pick drain and the block go idle.
	task automatic settle();
		in_valid <= 0;
		@(negedge clk);
		while (pending_count != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_fire_q);
		cfg_valid <= 0;
		case (idx)
			REG_PICK_X: cur_px = val;
			REG_PICK_Y: cur_py = val;
			REG_PICK_TOL: cur_tol = val[11:0];
			default: ;
		endcase
	endtask

	// A coordinate near the pick point, or anywhere at all.
	function automatic logic signed [15:0] coord(logic signed [15:0] centre, bit near);
		int span;
		span = cur_tol * 3 + 16;
		if (!near)
			return 16'($urandom);
		return 16'(centre + $signed($urandom_range(2 * span)) - span);
	endfunction

	task automatic random_config();
		int r;
		r = $urandom_range(9);
		write_reg(REG_PICK_X, r == 0 ? 16'h8000 : r == 1 ? 16'h7fff : 16'($urandom));
		r = $urandom_range(9);
		write_reg(REG_PICK_Y, r == 0 ? 16'h8000 : r == 1 ? 16'h7fff : 16'($urandom));
		r = $urandom_range(9);
		write_reg(REG_PICK_TOL, {4'($urandom), r == 0 ? 12'd0 : r == 1 ? 12'hfff :
			12'($urandom_range(4095))});
	endtask

	// One overlay list: a few polylines, mostly near the pick point.
	task automatic random_list(bit end_list);
		int npoly, len;
		bit near, noise;
		npoly = $urandom_range(1, 4);
		noise = $urandom_range(9) == 0;
		for (int p = 0; p < npoly; p++) begin
			len = $urandom_range(1, 6);
			near = $urandom_range(4) != 0;
			for (int j = 0; j < len; j++)
				put(coord(cur_px, near), coord(cur_py, near),
					noise ? bit'($urandom) : (j == 0),
					bit'($urandom), 10'($urandom_range(1023)),
					end_list && p == npoly - 1 && j == len - 1);
		end
	endtask

	initial begin
		int lists;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_valid = 0;
		cfg_index = REG_PICK_X;
		cfg_data = 0;
		quiet = 0;
		hold_go = 0;
		sent = 0;
		cur_px = 0;
		cur_py = 0;
		cur_tol = TolResetValue;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: extreme coordinates, segment through the pick point.
		put(16'sh8000, 16'sh8000, 1, 0, 0, 0);
		put(16'sh7fff, 16'sh7fff, 0, 1, 1023, 1);
		// First vertex without a start flag, then a degenerate segment.
		put(10, 0, 0, 1, 3, 0);
		put(10, 0, 0, 0, 7, 1);
		// Tie between two equal segments: the later one wins.
		put(-50, 20, 1, 0, 1, 0);
		put(50, 20, 0, 0, 5, 0);
		put(-50, 20, 1, 0, 1, 0);
		put(50, 20, 0, 1, 9, 1);
		// Projection clamped at both ends, then a lone last vertex.
		put(100, 0, 1, 0, 2, 0);
		put(200, 0, 0, 1, 4, 0);
		put(-300, 5, 1, 1, 6, 0);
		put(-100, 5, 0, 0, 8, 0);
		put(30, 30, 1, 1, 512, 1);
		put(999, 999, 1, 0, 0, 1);
		settle();
		// Zero tolerance with an exact hit.
		write_reg(REG_PICK_TOL, 16'd0);
		put(0, 0, 1, 0, 0, 0);
		put(0, 0, 0, 1, 11, 1);
		settle();
		// Widest tolerance, pick point at a corner, a far segment.
		write_reg(REG_PICK_TOL, 16'h0fff);
		write_reg(REG_PICK_X, 16'h7fff);
		write_reg(REG_PICK_Y, 16'h8000);
		put(0, 0, 1, 0, 1, 0);
		put(100, 100, 0, 1, 2, 1);
		settle();
		// Tolerance rewritten mid-list, first with no hit held, then with one.
		write_reg(REG_PICK_X, 16'd0);
		write_reg(REG_PICK_Y, 16'd0);
		write_reg(REG_PICK_TOL, 16'd4);
		put(5000, 5000, 1, 0, 1, 0);
		put(5000, 6000, 0, 0, 2, 0);
		settle();
		write_reg(REG_PICK_TOL, 16'd2000);
		put(0, 16, 0, 1, 3, 0);
		settle();
		write_reg(REG_PICK_TOL, 16'd1);
		put(-40, 16, 0, 0, 4, 1);
		settle();

		// Random lists with occasional reconfiguration.
		lists = 0;
		while (sent < 1600) begin
			if (sent > 300)
				hold_go = 1;
			quiet = sent > 700 && sent < 950;
			if (lists % 15 == 0) begin
				settle();
				random_config();
			end else if (lists % 37 == 5) begin
				// Partial list, tolerance rewrite while idle, then finish it.
				random_list(0);
				settle();
				write_reg(REG_PICK_TOL, 16'($urandom_range(4095)));
			end
			random_list(1);
			lists++;
		end
		settle();

		if (fail_count == 0)
			$display("nearest_segment_pick_tb OK");
		else
			$display("nearest_segment_pick_tb NOT OK");
		$finish;
	end
endmodule
